### rtl/asrenv_pkg.sv
// ----------------------------------------------------------------------------
// asrenv_pkg: shared types and constants of the ASR envelope amplifier
// Widths, full-scale level, step register reset values, register index codes
// and the configuration struct handed to the level tracker.
// ----------------------------------------------------------------------------
package asrenv_pkg;

  // Envelope level and step widths
  localparam int unsigned LevelW   = 19;
  localparam int unsigned StepW    = 19;
  localparam int unsigned SampleW  = 8;
  localparam int unsigned GainW    = 8;
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 32;

  // Full scale is 0xFF in the top byte of the level
  localparam logic [LevelW-1:0] FullScale = LevelW'(32'hFF << 11);

  localparam logic [StepW-1:0] AttackStepRst  = StepW'(100);
  localparam logic [StepW-1:0] ReleaseStepRst = StepW'(3);

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    RegAttackStep  = 8'd0,
    RegReleaseStep = 8'd1
  } asrenv_reg_e;

  // Step sizes currently in force
  typedef struct packed {
    logic [StepW-1:0] attack_step;
    logic [StepW-1:0] release_step;
  } asrenv_cfg_t;

endpackage

### rtl/asrenv_if.sv
// ----------------------------------------------------------------------------
// asrenv interfaces: input, output and configuration channels
// Valid/ready channels; a word moves at a clock edge with valid and ready high.
// ----------------------------------------------------------------------------
interface asrenv_in_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  gate_level;
  logic signed [asrenv_pkg::SampleW-1:0] sample_in;

  modport source (output valid, output gate_level, output sample_in, input ready);
  modport sink   (input valid, input gate_level, input sample_in, output ready);
endinterface

interface asrenv_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [asrenv_pkg::SampleW-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

interface asrenv_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [asrenv_pkg::CfgIdxW-1:0]       index;
  logic [asrenv_pkg::CfgDataW-1:0]      data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/asrenv_level.sv
// ----------------------------------------------------------------------------
// asrenv_level: envelope phase and level tracker
// Applies the gate, moves the level by at most one step per accepted word and
// hands out the top byte of the updated level as the gain for that word.
// ----------------------------------------------------------------------------
module asrenv_level (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              step_i,
  input  logic                              gate_i,
  input  asrenv_pkg::asrenv_cfg_t           cfg_i,
  output logic [asrenv_pkg::GainW-1:0]      gain_o
);

  typedef enum logic [1:0] {
    PhAttack  = 2'd0,
    PhSustain = 2'd1,
    PhRelease = 2'd2
  } phase_e;

  phase_e                             phase_q, phase_d, phase_g;
  logic [asrenv_pkg::LevelW-1:0]      level_q, level_d;
  logic [asrenv_pkg::LevelW:0]        attack_sum;

  // Apply the gate: rise from release starts attack, low gate forces release
  always_comb begin
    if (gate_i) begin
      phase_g = (phase_q == PhRelease) ? PhAttack : phase_q;
    end else begin
      phase_g = PhRelease;
    end
  end

  assign attack_sum = {1'b0, level_q} + {1'b0, cfg_i.attack_step};

  // Advance the level for the phase in force
  always_comb begin
    phase_d = phase_g;
    level_d = level_q;
    case (phase_g)
      PhAttack: begin
        if (level_q >= asrenv_pkg::FullScale) begin
          phase_d = PhSustain;
        end else if (attack_sum > {1'b0, asrenv_pkg::FullScale}) begin
          level_d = asrenv_pkg::FullScale;
        end else begin
          level_d = attack_sum[asrenv_pkg::LevelW-1:0];
        end
      end
      PhRelease: begin
        if (level_q < cfg_i.release_step) begin
          level_d = '0;
        end else begin
          level_d = level_q - cfg_i.release_step;
        end
      end
      default: begin
        level_d = level_q;
      end
    endcase
  end

  // Hold state between words
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhRelease;
      level_q <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      level_q <= level_d;
    end
  end

  // Gain is the top byte of the level after this word's step
  assign gain_o = level_d[asrenv_pkg::LevelW-1 -: asrenv_pkg::GainW];

`ifndef NO_ASSERTIONS
  property p_level_in_range;
    @(posedge clk_i) disable iff (!rst_ni) level_q <= asrenv_pkg::FullScale;
  endproperty
  a_level_in_range: assert property (p_level_in_range)
    else $error("envelope level above full scale");

  property p_sustain_full;
    @(posedge clk_i) disable iff (!rst_ni)
      (phase_q == PhSustain) |-> (level_q == asrenv_pkg::FullScale);
  endproperty
  a_sustain_full: assert property (p_sustain_full)
    else $error("sustain entered below full scale");

  property p_gate_low_release;
    @(posedge clk_i) disable iff (!rst_ni)
      (step_i && !gate_i) |=> (phase_q == PhRelease);
  endproperty
  a_gate_low_release: assert property (p_gate_low_release)
    else $error("low gate did not force release");
`endif

endmodule

### rtl/asr_envelope_amplifier.sv
// ----------------------------------------------------------------------------
// asr_envelope_amplifier: linear attack-sustain-release envelope on samples
// Shapes a stream of signed 8-bit samples with a gated linear envelope.
// ----------------------------------------------------------------------------
// Usage:
//   in_i  : one word per sample, carrying gate_level and sample_in.
//   out_o : one word per input word, carrying the shaped sample_out.
//   cfg_i : register writes (index 0 attack step, index 1 release step);
//           always ready, other indexes are ignored. Write only while idle.
// Timing:
//   Two register stages: the level update and gain capture, then the
//   8x8 multiply into the output register. The edge that takes an input
//   word loads stage 1; from there it moves into the output register,
//   which raises out_o.valid. One word is taken every cycle while out_o is taken.
//   The per-word level update (one add and compare) sets that rate.
// Stall:
//   When out_o is not taken, the output register holds its word and the
//   middle stage can still take one more input word before in_i drops ready.
// Reset:
//   Envelope starts in release at level zero; steps reset to 100 and 3.
// ----------------------------------------------------------------------------
module asr_envelope_amplifier (
  input  logic         clk_i,
  input  logic         rst_ni,
  asrenv_in_if.sink    in_i,
  asrenv_out_if.source out_o,
  asrenv_cfg_if.sink   cfg_i
);

  asrenv_pkg::asrenv_cfg_t              cfg_q;
  logic                                 in_fire;
  logic                                 s1_move;
  logic                                 s1_valid_q;
  logic                                 s1_neg_q;
  logic [asrenv_pkg::SampleW-1:0]       s1_mag_q;
  logic [asrenv_pkg::GainW-1:0]         s1_gain_q;
  logic [asrenv_pkg::GainW-1:0]         gain;
  logic [asrenv_pkg::SampleW-1:0]       mag;
  logic [asrenv_pkg::SampleW+asrenv_pkg::GainW-1:0] product;
  logic [asrenv_pkg::SampleW-1:0]       scaled;
  logic                                 out_valid_q;
  logic [asrenv_pkg::SampleW-1:0]       out_sample_q;

  // Configuration writes
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.attack_step  <= asrenv_pkg::AttackStepRst;
      cfg_q.release_step <= asrenv_pkg::ReleaseStepRst;
    end else if (cfg_i.valid) begin
      case (asrenv_pkg::asrenv_reg_e'(cfg_i.index))
        asrenv_pkg::RegAttackStep: begin
          cfg_q.attack_step <= cfg_i.data[asrenv_pkg::StepW-1:0];
        end
        asrenv_pkg::RegReleaseStep: begin
          cfg_q.release_step <= cfg_i.data[asrenv_pkg::StepW-1:0];
        end
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  // Pipeline handshake
  assign s1_move    = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_move;
  assign in_fire    = in_i.valid && in_i.ready;

  asrenv_level u_level (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (in_fire),
    .gate_i (in_i.gate_level),
    .cfg_i  (cfg_q),
    .gain_o (gain)
  );

  // Magnitude of the sample; -128 gives 128
  assign mag = in_i.sample_in[asrenv_pkg::SampleW-1] ? 8'(-in_i.sample_in)
                                                     : 8'(in_i.sample_in);

  // Stage 1: capture sign, magnitude and gain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_neg_q  <= in_i.sample_in[asrenv_pkg::SampleW-1];
      s1_mag_q  <= mag;
      s1_gain_q <= gain;
    end
  end

  // Stage 2: scale the magnitude and restore the sign
  assign product = s1_mag_q * s1_gain_q;
  assign scaled  = product[asrenv_pkg::SampleW+asrenv_pkg::GainW-1 -: asrenv_pkg::SampleW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || out_o.ready) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      out_sample_q <= s1_neg_q ? 8'(-scaled) : scaled;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.sample_out = out_sample_q;

endmodule
